>>> rtl/brd_pkg.sv
// Shared types, constants and helpers of the bitmask run decomposer.
// Depends on nothing; every other file imports it.
package brd_pkg;

    localparam int MASK_W   = 13;
    localparam int IDX_W    = 3;
    localparam int RANK_W   = 4;
    localparam int RANK_OFS = 2;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    typedef logic [MASK_W-1:0] t_mask;

    // One classified word as it travels from the front to the back.
    typedef struct packed {
        t_mask            mask;
        logic [IDX_W-1:0] total;
        logic             empty;
    } t_item;

    // Absolute rank of a one-hot bit position; zero when no bit is set.
    function automatic logic [RANK_W-1:0] f_top_rank(input t_mask onehot);
        logic [RANK_W-1:0] r;
        r = '0;
        for (int i = 0; i < MASK_W; i++) begin
            if (onehot[i]) begin
                r = r | RANK_W'(i + RANK_OFS);
            end
        end
        return r;
    endfunction

endpackage

>>> rtl/brd_front.sv
// Input stage of the bitmask run decomposer: takes a mask word, counts its runs.
// Depends on brd_pkg.
module brd_front import brd_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_suit_valid,
    output logic   o_suit_ready,
    input  t_mask  i_suit_mask,
    output logic   o_push,
    input  logic   i_q_ready,
    output t_item  o_item
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    t_mask starts;

    // A run starts wherever a set bit has a clear bit below it.
    always_comb begin
        logic [IDX_W-1:0] cnt;
        cnt    = '0;
        starts = i_suit_mask & ~{i_suit_mask[MASK_W-2:0], 1'b0};
        for (int i = 0; i < MASK_W; i++) begin
            cnt = cnt + {{(IDX_W-1){1'b0}}, starts[i]};
        end
        n_item.mask  = i_suit_mask;
        n_item.total = cnt;
        n_item.empty = (i_suit_mask == '0);
    end

    assign o_suit_ready = !r_valid || i_q_ready;
    assign o_push       = r_valid && i_q_ready;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_suit_ready) begin
            r_valid <= i_suit_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_suit_valid && o_suit_ready) begin
            r_item <= n_item;
        end
    end

endmodule

>>> rtl/brd_queue.sv
// Short queue of classified words between the front and the back.
// Depends on brd_pkg.
module brd_queue import brd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_ready,
    output logic  o_valid,
    input  logic  i_pop,
    output t_item o_item
);

    t_item             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_count;

    assign o_ready = (r_count != QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("queue fill count beyond depth");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue popped while empty");

endmodule

>>> rtl/brd_back.sv
// Run peeling stage: emits one run description per cycle into an output register unless stalled.
// Depends on brd_pkg.
module brd_back import brd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  t_item             i_q_item,
    output logic              o_pop,
    output logic              o_run_valid,
    input  logic              i_run_ready,
    output logic [IDX_W-1:0]  o_run_index,
    output logic [RANK_W-1:0] o_run_top_rank,
    output t_mask             o_run_lower_bits,
    output t_mask             o_run_all_bits,
    output t_mask             o_gap_bits,
    output logic [IDX_W-1:0]  o_run_total,
    output logic              o_is_empty,
    output logic              o_is_last
);

    logic             r_act;
    t_mask            r_rem;
    t_mask            r_above;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_total;
    logic             r_empty;

    logic              r_ovalid;
    logic [IDX_W-1:0]  r_oidx;
    logic [RANK_W-1:0] r_orank;
    t_mask             r_olower;
    t_mask             r_oall;
    t_mask             r_ogap;
    logic [IDX_W-1:0]  r_ototal;
    logic              r_oempty;
    logic              r_olast;

    t_mask low, sum, all, top, gap, n_rem, n_above;
    logic  out_en, emit, last, load;

    // The lowest set bit, added back in, carries through the whole run.
    always_comb begin
        low     = r_rem & (~r_rem + 1'b1);
        sum     = r_rem + low;
        all     = r_rem & ~sum;
        top     = all & ~{1'b0, all[MASK_W-1:1]};
        gap     = r_above & (low - 1'b1);
        n_rem   = r_rem & ~all;
        n_above = ~(top | (top - 1'b1));
        last    = r_empty || (n_rem == '0);
    end

    assign out_en = !r_ovalid || i_run_ready;
    assign emit   = out_en && r_act;
    assign load   = i_q_valid && (!r_act || (emit && last));
    assign o_pop  = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (load) begin
                r_act <= 1'b1;
            end else if (emit && last) begin
                r_act <= 1'b0;
            end
            if (out_en) begin
                r_ovalid <= r_act;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rem   <= i_q_item.mask;
            r_above <= '0;
            r_idx   <= '0;
            r_total <= i_q_item.total;
            r_empty <= i_q_item.empty;
        end else if (emit) begin
            r_rem   <= n_rem;
            r_above <= n_above;
            r_idx   <= r_idx + 1'b1;
        end
        if (emit) begin
            r_oidx   <= r_idx;
            r_orank  <= f_top_rank(top);
            r_olower <= all ^ top;
            r_oall   <= all;
            r_ogap   <= gap;
            r_ototal <= r_total;
            r_oempty <= r_empty;
            r_olast  <= last;
        end
    end

    assign o_run_valid      = r_ovalid;
    assign o_run_index      = r_oidx;
    assign o_run_top_rank   = r_orank;
    assign o_run_lower_bits = r_olower;
    assign o_run_all_bits   = r_oall;
    assign o_gap_bits       = r_ogap;
    assign o_run_total      = r_ototal;
    assign o_is_empty       = r_oempty;
    assign o_is_last        = r_olast;

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_oempty) |-> r_olast)
        else $error("empty result not marked last");

    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_oempty) |-> (r_oidx < r_ototal))
        else $error("run index not below run total");

    a_runs_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_act && !r_empty) |-> (r_rem != '0))
        else $error("active word has no runs left");

    a_stay_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && !last) |=> r_act)
        else $error("word dropped before its last run");

endmodule

>>> rtl/bitmask_run_decomposer.sv
// Top level of the bitmask run decomposer: front stage, queue and run peeling back end.
// Depends on brd_pkg, brd_front, brd_queue and brd_back.
//
//   Channel   Direction  Handshake                     Word
//   suit      in         i_suit_valid / o_suit_ready   i_suit_mask
//   run       out        o_run_valid  / i_run_ready    o_run_index .. o_is_last
//
// The back end delivers one run description per cycle unless the run channel stalls,
// giving n for a mask with n runs (one for an empty mask), at most seven in all.
// The front stage takes a new mask word every cycle while the four-word queue
// has room; a word goes through the front register, queue and back end to the output.
// Reset clears only the valid flags, queue pointers and queue count. A stall on the run
// channel holds the output register and backs up through the queue to the front.
module bitmask_run_decomposer import brd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_suit_valid,
    output logic              o_suit_ready,
    input  logic [MASK_W-1:0] i_suit_mask,
    output logic              o_run_valid,
    input  logic              i_run_ready,
    output logic [IDX_W-1:0]  o_run_index,
    output logic [RANK_W-1:0] o_run_top_rank,
    output logic [MASK_W-1:0] o_run_lower_bits,
    output logic [MASK_W-1:0] o_run_all_bits,
    output logic [MASK_W-1:0] o_gap_bits,
    output logic [IDX_W-1:0]  o_run_total,
    output logic              o_is_empty,
    output logic              o_is_last
);

    // The front classifies each word (run count, empty flag) and hands it on.
    logic  push;
    logic  q_ready;
    t_item front_item;

    // The queue lets the front keep taking words while the back peels runs.
    logic  q_valid;
    logic  pop;
    t_item q_item;

    brd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_suit_valid (i_suit_valid),
        .o_suit_ready (o_suit_ready),
        .i_suit_mask  (i_suit_mask),
        .o_push       (push),
        .i_q_ready    (q_ready),
        .o_item       (front_item)
    );

    brd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_item  (q_item)
    );

    // The back strips the lowest run off the word each cycle unless the run channel stalls, and moves on to
    // the next queued word in the same cycle as it emits the last run.
    brd_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_q_item         (q_item),
        .o_pop            (pop),
        .o_run_valid      (o_run_valid),
        .i_run_ready      (i_run_ready),
        .o_run_index      (o_run_index),
        .o_run_top_rank   (o_run_top_rank),
        .o_run_lower_bits (o_run_lower_bits),
        .o_run_all_bits   (o_run_all_bits),
        .o_gap_bits       (o_gap_bits),
        .o_run_total      (o_run_total),
        .o_is_empty       (o_is_empty),
        .o_is_last        (o_is_last)
    );

endmodule
